// ===== rtl/core/led_blink_pattern_engine_core_assert.svh =====
// assertion macros for the led blink pattern engine
`ifndef LED_BLINK_PATTERN_ENGINE_CORE_ASSERT_SVH
`define LED_BLINK_PATTERN_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LBPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define LBPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lbpe_pkg.sv =====
// shared constants, codes and pattern table of the led blink pattern engine
`default_nettype none

package lbpe_pkg;

    localparam int PATTERN_W    = 32;
    localparam int PTR_W        = 5;
    localparam int COUNT_W      = 16;
    localparam int IDX_W        = 2;
    localparam int SEL_W        = 4;
    localparam int LEVELS_W     = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam int NUM_LEDS_DEF     = 3;
    localparam int NUM_PATTERNS_DEF = 12;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREVER_CODE = 1'b1;

    localparam logic [COUNT_W-1:0] DISABLE_CODE_RST = 16'h0000;
    localparam logic [COUNT_W-1:0] FOREVER_CODE_RST = 16'hFFFF;

    // fixed blink patterns, bit n is shown at bit position n
    function automatic logic [PATTERN_W-1:0] pattern_word(input logic [SEL_W-1:0] sel);
        logic [PATTERN_W-1:0] word;
        unique case (sel)
            4'd0:    word = 32'h0000_0000; // off
            4'd1:    word = 32'hFFFF_FFFF; // on
            4'd2:    word = 32'h0000_0001; // one flash
            4'd3:    word = 32'h8000_8000; // two flashes
            4'd4:    word = 32'h8100_8080; // four flashes
            4'd5:    word = 32'hFFFF_0000; // slow
            4'd6:    word = 32'hF0F0_F0F0; // normal
            4'd7:    word = 32'hCCCC_CCCC; // fast
            4'd8:    word = 32'h9273_9C92; // sos
            4'd9:    word = 32'hAAAA_AAAA; // jitter one
            4'd10:   word = 32'h9249_2492; // jitter two
            4'd11:   word = 32'h8888_8888; // jitter three
            default: word = 32'h0000_0000;
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lbpe_req_if.sv =====
// command channel: tick or set beat into the engine
`default_nettype none

interface lbpe_req_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [lbpe_pkg::IDX_W-1:0]      led_index;
    logic [lbpe_pkg::SEL_W-1:0]      pattern_select;
    logic [lbpe_pkg::COUNT_W-1:0]    tick_count;

    modport source (
        output valid, op, led_index, pattern_select, tick_count,
        input  ready
    );

    modport sink (
        input  valid, op, led_index, pattern_select, tick_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/lbpe_rsp_if.sv =====
// result channel: led levels and bit position out of the engine
`default_nettype none

interface lbpe_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lbpe_pkg::LEVELS_W-1:0]   led_levels;
    logic [lbpe_pkg::PTR_W-1:0]      bit_position;

    modport source (
        output valid, led_levels, bit_position,
        input  ready
    );

    modport sink (
        input  valid, led_levels, bit_position,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/led_blink_pattern_engine_core.sv =====
// top level of the led blink pattern engine
// result: the result beat of a command is valid in the cycle after it is accepted
// throughput: one command per cycle unless the result stalls; the per-led update and the
//   bit position step are one level of logic ahead of the state and result registers
// reset: all leds disabled and low, bit position zero, codes back to defaults
`default_nettype none

module led_blink_pattern_engine_core #(
    parameter int NUM_LEDS     = lbpe_pkg::NUM_LEDS_DEF,
    parameter int NUM_PATTERNS = lbpe_pkg::NUM_PATTERNS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lbpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lbpe_pkg::CFG_DATA_W-1:0]     cfg_data,
    lbpe_req_if.sink                                 req,
    lbpe_rsp_if.source                               rsp
);

`include "led_blink_pattern_engine_core_assert.svh"

    localparam int PW    = lbpe_pkg::PATTERN_W;
    localparam int CW    = lbpe_pkg::COUNT_W;
    localparam int LW    = lbpe_pkg::LEVELS_W;
    localparam int PAD_W = NUM_LEDS + LW;

    // configuration codes
    logic [CW-1:0] dis_code_reg;
    logic [CW-1:0] fv_code_reg;

    // per-led state
    logic [NUM_LEDS-1:0][PW-1:0] pat_reg,   pat_next;
    logic [NUM_LEDS-1:0][CW-1:0] ticks_reg, ticks_next;
    logic [NUM_LEDS-1:0]         en_reg,    en_next;
    logic [NUM_LEDS-1:0]         fv_reg,    fv_next;
    logic [NUM_LEDS-1:0]         lvl_reg,   lvl_next;

    // shared bit position
    logic [lbpe_pkg::PTR_W-1:0]  bit_ptr_reg, bit_ptr_next;

    // result register
    logic                        rsp_vld_reg;
    logic [LW-1:0]               rsp_lvl_reg;
    logic [lbpe_pkg::PTR_W-1:0]  rsp_pos_reg;

    logic                        req_acc;
    logic                        is_set;
    logic                        is_tick;
    logic                        sel_ok;
    logic [PW-1:0]               set_pat;
    logic [PAD_W-1:0]            lvl_pad;

    // a new beat is taken whenever the result slot is free or being drained
    assign req.ready = !rsp_vld_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;
    assign is_set    = req_acc && (req.op == lbpe_pkg::OP_SET);
    assign is_tick   = req_acc && (req.op == lbpe_pkg::OP_TICK);

    // selectors past the configured pattern count load the off pattern
    assign sel_ok  = (32'(req.pattern_select) < NUM_PATTERNS);
    assign set_pat = sel_ok ? lbpe_pkg::pattern_word(req.pattern_select) : '0;

    // per-led update, every led is independent of the others
    always_comb
    begin
        pat_next   = pat_reg;
        ticks_next = ticks_reg;
        en_next    = en_reg;
        fv_next    = fv_reg;
        lvl_next   = lvl_reg;
        for (int k = 0; k < NUM_LEDS; k++)
        begin
            // set command: load pattern and count; index past the last led hits nothing
            if (is_set && (32'(req.led_index) == k))
            begin
                pat_next[k]   = set_pat;
                ticks_next[k] = req.tick_count;
                en_next[k]    = (req.tick_count != dis_code_reg);
                fv_next[k]    = (req.tick_count == fv_code_reg);
            end
            // tick: disabled leds hold their level
            if (is_tick && en_reg[k])
            begin
                if ((ticks_reg[k] != '0) || fv_reg[k])
                begin
                    lvl_next[k] = pat_reg[k][bit_ptr_reg];
                end
                if (!fv_reg[k])
                begin
                    if (ticks_reg[k] == '0)
                    begin
                        lvl_next[k] = 1'b0;
                    end
                    else
                    begin
                        ticks_next[k] = ticks_reg[k] - 1'b1;
                    end
                end
            end
        end
    end

    // bit position wraps naturally at 32
    assign bit_ptr_next = is_tick ? bit_ptr_reg + 1'b1 : bit_ptr_reg;

    // only the first three leds reach the level output, missing ones read low
    assign lvl_pad = {{LW{1'b0}}, lvl_next};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dis_code_reg <= lbpe_pkg::DISABLE_CODE_RST;
            fv_code_reg  <= lbpe_pkg::FOREVER_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lbpe_pkg::CFG_DISABLE_CODE: dis_code_reg <= cfg_data;
                lbpe_pkg::CFG_FOREVER_CODE: fv_code_reg  <= cfg_data;
                default:                    dis_code_reg <= dis_code_reg;
            endcase
        end
    end

    // led state and bit position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg     <= '0;
            ticks_reg   <= '0;
            en_reg      <= '0;
            fv_reg      <= '0;
            lvl_reg     <= '0;
            bit_ptr_reg <= '0;
        end
        else if (req_acc)
        begin
            pat_reg     <= pat_next;
            ticks_reg   <= ticks_next;
            en_reg      <= en_next;
            fv_reg      <= fv_next;
            lvl_reg     <= lvl_next;
            bit_ptr_reg <= bit_ptr_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else if (req_acc)
        begin
            rsp_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_reg <= 1'b0;
        end
    end

    // result payload, loaded with the state after the accepted beat
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            rsp_lvl_reg <= lvl_pad[LW-1:0];
            rsp_pos_reg <= bit_ptr_next;
        end
    end

    assign rsp.valid        = rsp_vld_reg;
    assign rsp.led_levels   = rsp_lvl_reg;
    assign rsp.bit_position = rsp_pos_reg;

    // a tick steps the bit position by one
    `LBPE_ASSERT_NEXT(a_tick_steps_ptr, is_tick,
        bit_ptr_reg == 5'($past(bit_ptr_reg) + 5'd1), "bit position did not step on tick")

    // a set beat leaves levels and bit position alone
    `LBPE_ASSERT_NEXT(a_set_holds_levels, is_set,
        $stable(bit_ptr_reg) && $stable(lvl_reg), "set beat changed levels or position")

    // disabled leds keep their level across a tick
    `LBPE_ASSERT_NEXT(a_disabled_hold, is_tick,
        ((lvl_reg ^ $past(lvl_reg)) & ~$past(en_reg)) == '0, "disabled led changed level")

    // nothing moves without an accepted beat
    `LBPE_ASSERT_NEXT(a_idle_stable, !req_acc,
        $stable(bit_ptr_reg) && $stable(ticks_reg) && $stable(lvl_reg),
        "led state changed without a beat")

    // result slot fills only from an accepted beat
    `LBPE_ASSERT_NOW(a_rsp_from_beat, $rose(rsp_vld_reg),
        $past(req_acc), "result appeared without an accepted beat")

endmodule

`default_nettype wire
